/* sv/ssta_pkg.sv */
// types, codes and mask tables for the seven-segment transition animator
// no dependencies; imported by every module of the block
package ssta_pkg;

	localparam logic FUNC_SET  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam int MAX_FRAME = 16;

	typedef struct packed {
		logic       func;
		logic [3:0] digit_select;
		logic [7:0] new_segments;
		logic [2:0] anim_kind;
		logic       force_replay;
	} item_t;

	typedef struct packed {
		logic [3:0] digit_index;
		logic [7:0] segment_drive;
		logic       frame_end;
	} result_t;

	// one memory word per digit
	typedef struct packed {
		logic [7:0] target_code;
		logic [7:0] prior_code;
		logic [2:0] kind_store;
		logic [2:0] step_count;
		logic       replay_pending;
		logic [7:0] shown_code;
	} digit_rec_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SET,
		ST_TICK
	} ctl_state_t;

	// mask per kind and step; unused steps are zero
	localparam logic [7:0] MASK_TABLE [8][8] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h01, 8'h03, 8'h43, 8'h47, 8'h4f, 8'h5f, 8'h00, 8'h00},
		'{8'h01, 8'h21, 8'h61, 8'h71, 8'h79, 8'h7d, 8'h00, 8'h00},
		'{8'h01, 8'h21, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h08, 8'h0c, 8'h5e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h10, 8'h18, 8'h7c, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h04, 8'h0c, 8'h5e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [2:0] MASK_COUNT [8] = '{
		3'd0, 3'd6, 3'd6, 3'd3, 3'd3, 3'd3, 3'd3, 3'd0
	};

endpackage

/* sv/ssta_digit_mem.sv */
// per-digit state memory: one write port, one registered read port
// entries read as zero until first written (valid bit per entry)
// depends on ssta_pkg
module ssta_digit_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output ssta_pkg::digit_rec_t rd_data,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  ssta_pkg::digit_rec_t wr_data
);
	import ssta_pkg::*;

	digit_rec_t mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	digit_rec_t rdata_q;
	logic rvalid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

/* sv/ssta_advance.sv */
// one animation step of a single digit on a tick
// depends on ssta_pkg mask tables
module ssta_advance (
	input  ssta_pkg::digit_rec_t cur,
	output ssta_pkg::digit_rec_t nxt,
	output logic [7:0]           drive
);
	import ssta_pkg::*;

	logic       active;
	logic [7:0] mask;

	assign active = (cur.target_code != cur.prior_code) || cur.replay_pending;
	assign mask   = MASK_TABLE[cur.kind_store][cur.step_count];

	always_comb begin
		nxt   = cur;
		drive = cur.shown_code;
		if (active) begin
			nxt.replay_pending = 1'b0;
			if (cur.step_count < MASK_COUNT[cur.kind_store]) begin
				drive          = (cur.target_code & mask) | (cur.prior_code & ~mask);
				nxt.step_count = cur.step_count + 3'd1;
			end else begin
				// animation done: adopt the target
				drive          = cur.target_code;
				nxt.prior_code = cur.target_code;
				nxt.step_count = 3'd0;
			end
			nxt.shown_code = drive;
		end
	end

endmodule

/* sv/seven_segment_transition_animator_core.sv */
// seven-segment transition animator, top level
// set transaction: memory read, then write back, no result
// tick transaction: one digit per cycle through the memory while the result register is free; each result
// passes the memory read register and then the result register, min(DIGITS,16) results per tick
// reset: all digit state reads as zero at once through per-entry valid bits
module seven_segment_transition_animator_core #(
	parameter int DIGITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  ssta_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output ssta_pkg::result_t result
);
	import ssta_pkg::*;

	// digits past the addressable range are never written and never emitted
	localparam int NUM = (DIGITS < MAX_FRAME) ? DIGITS : MAX_FRAME;
	localparam int AW  = (NUM > 1) ? $clog2(NUM) : 1;

	ctl_state_t state_q, state_d;
	logic [AW-1:0] idx_q;
	item_t set_q;
	result_t result_q;
	logic result_valid_q;

	logic rd_en, wr_en, load_res, idx_inc, idx_clr, out_free, last, in_range;
	logic [AW-1:0] rd_addr, wr_addr;
	digit_rec_t rd_data, wr_data, adv_rec, set_rec;
	logic [7:0] adv_drive;

	ssta_digit_mem #(.DEPTH(NUM), .AW(AW)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	ssta_advance u_adv (
		.cur   (rd_data),
		.nxt   (adv_rec),
		.drive (adv_drive)
	);

	assign out_free = !result_valid_q || !result_stall;
	assign last     = (idx_q == AW'(NUM - 1));
	assign in_range = ({1'b0, item.digit_select} < 5'(NUM));

	always_comb begin
		set_rec                = rd_data;
		set_rec.target_code    = set_q.new_segments;
		set_rec.kind_store     = set_q.anim_kind;
		set_rec.replay_pending = rd_data.replay_pending | set_q.force_replay;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			idx_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_res) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			set_q <= item;
		end
		if (load_res) begin
			result_q.digit_index   <= 4'(idx_q);
			result_q.segment_drive <= adv_drive;
			result_q.frame_end     <= last;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		rd_en      = 1'b0;
		rd_addr    = idx_q;
		wr_en      = 1'b0;
		wr_addr    = idx_q;
		wr_data    = adv_rec;
		load_res   = 1'b0;
		idx_inc    = 1'b0;
		idx_clr    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					if (item.func == FUNC_TICK) begin
						rd_en   = 1'b1;
						rd_addr = '0;
						idx_clr = 1'b1;
						state_d = ST_TICK;
					end else if (in_range) begin
						rd_en   = 1'b1;
						rd_addr = item.digit_select[AW-1:0];
						state_d = ST_SET;
					end
				end
			end
			ST_SET: begin
				wr_en   = 1'b1;
				wr_addr = set_q.digit_select[AW-1:0];
				wr_data = set_rec;
				state_d = ST_IDLE;
			end
			ST_TICK: begin
				// write back and emit only when the result register can take it
				if (out_free) begin
					wr_en    = 1'b1;
					load_res = 1'b1;
					if (last) begin
						state_d = ST_IDLE;
					end else begin
						idx_inc = 1'b1;
						rd_en   = 1'b1;
						rd_addr = idx_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TICK |-> idx_q <= AW'(NUM - 1))
		else $error("digit index past last digit during tick");

	a_frame_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK && load_res && last) |=> state_q == ST_IDLE)
		else $error("tick did not finish after last digit");

	a_set_path: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.func == FUNC_SET && in_range)
		|=> (state_q == ST_SET && !item_stall == 1'b0))
		else $error("set transaction did not enter write-back");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !wr_en)
		else $error("memory write while idle");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for seven_segment_transition_animator_core
// depends on ssta_pkg for the transaction structs and function codes
module testbench;
	import ssta_pkg::*;

	localparam int NUM_DIGITS     = 16;
	localparam int FRAME_LEN      = (NUM_DIGITS < MAX_FRAME) ? NUM_DIGITS : MAX_FRAME;
	localparam int RANDOM_ITEMS   = 104;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int HOLDOFF_AFTER  = 45;
	localparam int IDLE_LIMIT     = 3000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PRINT_LIMIT    = 50;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_CLOCKWISE,
		KIND_ANTICLOCKWISE,
		KIND_UP_DOWN,
		KIND_DOWN_UP,
		KIND_LEFT_RIGHT,
		KIND_RIGHT_LEFT,
		KIND_UNUSED
	} anim_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	seven_segment_transition_animator_core #(
		.DIGITS(NUM_DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// display model, one entry per digit
	logic [7:0] model_target [NUM_DIGITS];
	logic [7:0] model_prior [NUM_DIGITS];
	logic [7:0] model_shown [NUM_DIGITS];
	logic [2:0] model_kind [NUM_DIGITS];
	logic [2:0] model_step [NUM_DIGITS];
	logic       model_replay [NUM_DIGITS];

	// last pattern queued for each digit, reused so replays of unchanged content occur
	logic [7:0] last_written [16];

	item_t   stim_queue [$];
	result_t expected_drives [$];

	int error_count = 0;
	int items_accepted = 0;
	int idle_cycles = 0;
	logic item_taken = 1'b0;

	function automatic int sweep_length(input logic [2:0] kind);
		case (kind)
			KIND_CLOCKWISE, KIND_ANTICLOCKWISE: sweep_length = 6;
			KIND_UP_DOWN, KIND_DOWN_UP, KIND_LEFT_RIGHT, KIND_RIGHT_LEFT: sweep_length = 3;
			default: sweep_length = 0;
		endcase
	endfunction

	function automatic logic [7:0] sweep_mask(input logic [2:0] kind, input logic [2:0] step);
		logic [7:0] m;
		m = 8'h00;
		case (kind)
			KIND_CLOCKWISE: begin
				case (step)
					3'd0: m = 8'h01;
					3'd1: m = 8'h03;
					3'd2: m = 8'h43;
					3'd3: m = 8'h47;
					3'd4: m = 8'h4f;
					3'd5: m = 8'h5f;
					default: m = 8'h00;
				endcase
			end
			KIND_ANTICLOCKWISE: begin
				case (step)
					3'd0: m = 8'h01;
					3'd1: m = 8'h21;
					3'd2: m = 8'h61;
					3'd3: m = 8'h71;
					3'd4: m = 8'h79;
					3'd5: m = 8'h7d;
					default: m = 8'h00;
				endcase
			end
			KIND_UP_DOWN: begin
				case (step)
					3'd0: m = 8'h01;
					3'd1: m = 8'h21;
					3'd2: m = 8'h73;
					default: m = 8'h00;
				endcase
			end
			KIND_DOWN_UP: begin
				case (step)
					3'd0: m = 8'h08;
					3'd1: m = 8'h0c;
					3'd2: m = 8'h5e;
					default: m = 8'h00;
				endcase
			end
			KIND_LEFT_RIGHT: begin
				case (step)
					3'd0: m = 8'h10;
					3'd1: m = 8'h18;
					3'd2: m = 8'h7c;
					default: m = 8'h00;
				endcase
			end
			KIND_RIGHT_LEFT: begin
				case (step)
					3'd0: m = 8'h04;
					3'd1: m = 8'h0c;
					3'd2: m = 8'h5e;
					default: m = 8'h00;
				endcase
			end
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	task automatic update_display(input item_t it);
		logic [7:0] m;
		result_t r;
		if (it.func == FUNC_SET) begin
			if (it.digit_select < NUM_DIGITS) begin
				model_target[it.digit_select] = it.new_segments;
				model_kind[it.digit_select] = it.anim_kind;
				if (it.force_replay)
					model_replay[it.digit_select] = 1'b1;
			end
		end else begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (model_target[d] != model_prior[d] || model_replay[d]) begin
					model_replay[d] = 1'b0;
					if (model_step[d] < sweep_length(model_kind[d])) begin
						m = sweep_mask(model_kind[d], model_step[d]);
						model_shown[d] = (model_target[d] & m) | (model_prior[d] & ~m);
						model_step[d] = model_step[d] + 3'd1;
					end else begin
						model_prior[d] = model_target[d];
						model_step[d] = 3'd0;
						model_shown[d] = model_target[d];
					end
				end
			end
			for (int d = 0; d < FRAME_LEN; d++) begin
				r.digit_index = d[3:0];
				r.segment_drive = model_shown[d];
				r.frame_end = (d == FRAME_LEN - 1);
				expected_drives.push_back(r);
			end
		end
	endtask

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic queue_set(input logic [3:0] sel, input logic [7:0] seg,
			input logic [2:0] kind, input logic frc);
		item_t it;
		it.func = FUNC_SET;
		it.digit_select = sel;
		it.new_segments = seg;
		it.anim_kind = kind;
		it.force_replay = frc;
		stim_queue.push_back(it);
		last_written[sel] = seg;
	endtask

	// tick transactions carry random content in the fields they ignore
	task automatic queue_tick();
		item_t it;
		it = item_t'($urandom);
		it.func = FUNC_TICK;
		stim_queue.push_back(it);
	endtask

	task automatic build_stimulus();
		int count;
		int sets;
		int ticks;
		logic [3:0] sel;
		logic [7:0] seg;
		item_t it;
		// reset state, then every kind at once
		queue_tick();
		queue_set(4'd0, 8'hff, KIND_CLOCKWISE, 1'b0);
		queue_set(4'd15, 8'h80, KIND_ANTICLOCKWISE, 1'b0);
		// unchanged content replayed with the unused kind
		queue_set(4'd1, 8'h00, KIND_UNUSED, 1'b1);
		queue_set(4'd2, 8'h5a, KIND_UP_DOWN, 1'b0);
		queue_set(4'd3, 8'ha5, KIND_DOWN_UP, 1'b0);
		queue_set(4'd4, 8'h3c, KIND_LEFT_RIGHT, 1'b0);
		queue_set(4'd5, 8'hc3, KIND_RIGHT_LEFT, 1'b0);
		queue_set(4'd6, 8'h7f, KIND_NONE, 1'b0);
		repeat (4) queue_tick();
		// change the target while the sweep is still running
		queue_set(4'd0, 8'h0f, KIND_CLOCKWISE, 1'b0);
		repeat (3) queue_tick();
		queue_set(4'd7, 8'h00, KIND_NONE, 1'b1);
		queue_set(4'd15, 8'h80, KIND_ANTICLOCKWISE, 1'b1);
		repeat (5) queue_tick();

		count = 0;
		while (count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				it = item_t'($urandom);
				stim_queue.push_back(it);
				if (it.func == FUNC_SET)
					last_written[it.digit_select] = it.new_segments;
				count++;
			end else begin
				sets = $urandom_range(1, 4);
				ticks = $urandom_range(1, 7);
				repeat (sets) begin
					sel = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
					case ($urandom_range(0, 5))
						0: seg = 8'h00;
						1: seg = 8'hff;
						2: seg = model_seg_hint(sel);
						default: seg = 8'($urandom);
					endcase
					queue_set(sel, seg, 3'($urandom_range(0, 7)),
						($urandom_range(0, 4) == 0));
				end
				repeat (ticks) queue_tick();
				count += sets + ticks;
			end
		end
	endtask

	function automatic logic [7:0] model_seg_hint(input logic [3:0] sel);
		return last_written[sel];
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			item_taken <= item_valid && !item_stall;
			if (item_valid && !item_stall) begin
				update_display(item);
				items_accepted++;
			end
			if (result_valid && !result_stall) begin
				if (expected_drives.size() == 0) begin
					report_mismatch($sformatf("unexpected result digit %0d drive 0x%02h",
						result.digit_index, result.segment_drive));
				end else begin
					if (result.digit_index != expected_drives[0].digit_index)
						report_mismatch($sformatf("digit_index got %0d want %0d",
							result.digit_index, expected_drives[0].digit_index));
					if (result.segment_drive != expected_drives[0].segment_drive)
						report_mismatch($sformatf("digit %0d segment_drive got 0x%02h want 0x%02h",
							expected_drives[0].digit_index, result.segment_drive,
							expected_drives[0].segment_drive));
					if (result.frame_end != expected_drives[0].frame_end)
						report_mismatch($sformatf("digit %0d frame_end got %0b want %0b",
							expected_drives[0].digit_index, result.frame_end,
							expected_drives[0].frame_end));
					void'(expected_drives.pop_front());
				end
			end
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// sender: bursts of random length separated by random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (item_valid && !item_taken) begin
			// payload held until taken
		end else if (gap_left > 0 || stim_queue.size() == 0) begin
			item_valid <= 1'b0;
			if (gap_left > 0)
				gap_left--;
		end else begin
			item <= stim_queue.pop_front();
			item_valid <= 1'b1;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 12);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left--;
			end
		end
	end

	// receiver: stall pattern switches at random among four modes, plus one long hold-off
	int rx_cycle = 0;
	int rx_mode = 0;
	int holdoff_left = 0;
	logic holdoff_done = 1'b0;
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 50 == 0)
			rx_mode = $urandom_range(0, 3);
		if (!holdoff_done && items_accepted >= HOLDOFF_AFTER) begin
			holdoff_done = 1'b1;
			holdoff_left = HOLDOFF_CYCLES;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			result_stall <= 1'b1;
		end else begin
			case (rx_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				2: result_stall <= ($urandom_range(0, 9) < 7);
				default: result_stall <= ((rx_cycle % 8) < 3);
			endcase
		end
	end

	initial begin
		for (int d = 0; d < NUM_DIGITS; d++) begin
			model_target[d] = 8'h00;
			model_prior[d] = 8'h00;
			model_shown[d] = 8'h00;
			model_kind[d] = KIND_NONE;
			model_step[d] = 3'd0;
			model_replay[d] = 1'b0;
		end
		for (int d = 0; d < 16; d++)
			last_written[d] = 8'h00;
		build_stimulus();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (stim_queue.size() != 0 || item_valid)
			@(negedge clk);
		while (expected_drives.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_drives.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_drives.size()));
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
